>>> hdl/ttg_pkg.sv
// ----------------------------------------------------------------------------
// Triangle tangent generator - shared package
// Field widths, the 64-bit saturating carrier and small helpers on it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ttg_pkg;

	localparam int LANES   = 3;
	localparam int POS_W   = 48;
	localparam int UV_W    = 32;
	localparam int NRM_W   = 48;
	localparam int TAN_W   = 48;
	localparam int WORD_W  = 64;
	localparam int MAG_W   = 63;
	localparam int HALF_W  = 32;
	localparam int EXT_W   = 128;
	localparam int UV_FRAC = 12;

	localparam logic signed [EXT_W-1:0] SAT_HI =
		{{(EXT_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
	localparam logic signed [EXT_W-1:0] SAT_LO = -SAT_HI;

	// Clamp a wide signed value to the symmetric 64-bit range
	function automatic logic signed [WORD_W-1:0] sat64(input logic signed [EXT_W-1:0] v);
		logic signed [WORD_W-1:0] r;
		if (v > SAT_HI) begin
			r = SAT_HI[WORD_W-1:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[WORD_W-1:0];
		end else begin
			r = v[WORD_W-1:0];
		end
		return r;
	endfunction

	// Magnitude of a value inside the symmetric range
	function automatic logic [MAG_W-1:0] mag63(input logic signed [WORD_W-1:0] v);
		logic [WORD_W-1:0] neg;
		neg = -v;
		return v[WORD_W-1] ? neg[MAG_W-1:0] : v[MAG_W-1:0];
	endfunction

	// Apply a sign to a magnitude
	function automatic logic signed [WORD_W-1:0] sgn_val(input logic [MAG_W-1:0] m,
		input logic neg);
		logic signed [WORD_W-1:0] p;
		p = {1'b0, m};
		return neg ? -p : p;
	endfunction

endpackage

`default_nettype wire

>>> hdl/ttg_div.sv
// ----------------------------------------------------------------------------
// Triangle tangent generator - pipelined divider
// Unsigned restoring division, one quotient bit per stage, several lanes
// sharing one divisor, with a side vector that travels along.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttg_div #(
	parameter int N      = 63,
	parameter int SIDE_W = 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [ttg_pkg::LANES*N-1:0]  dvd,
	input  logic [N-1:0]                 dvsr,
	input  logic [SIDE_W-1:0]            side_in,
	output logic                         out_valid,
	output logic [ttg_pkg::LANES*N-1:0]  quo,
	output logic [SIDE_W-1:0]            side_out
);
	import ttg_pkg::*;

	logic              valid_s [N];
	logic [N-1:0]      dvsr_s  [N];
	logic [N-1:0]      rem_s   [N][LANES];
	logic [N-1:0]      dq_s    [N][LANES];
	logic [SIDE_W-1:0] side_s  [N];

	for (genvar i = 0; i < N; i++) begin : g_stage
		logic              v_prev;
		logic [N-1:0]      dvsr_prev;
		logic [N-1:0]      rem_prev [LANES];
		logic [N-1:0]      dq_prev  [LANES];
		logic [SIDE_W-1:0] side_prev;
		logic [N:0]        trial    [LANES];
		logic [N-1:0]      rem_nx   [LANES];
		logic [N-1:0]      dq_nx    [LANES];

		// Select the stage inputs
		if (i == 0) begin : g_first
			always_comb begin
				v_prev    = in_valid;
				dvsr_prev = dvsr;
				side_prev = side_in;
				for (int l = 0; l < LANES; l++) begin
					rem_prev[l] = '0;
					dq_prev[l]  = dvd[l*N +: N];
				end
			end
		end else begin : g_next
			always_comb begin
				v_prev    = valid_s[i-1];
				dvsr_prev = dvsr_s[i-1];
				side_prev = side_s[i-1];
				for (int l = 0; l < LANES; l++) begin
					rem_prev[l] = rem_s[i-1][l];
					dq_prev[l]  = dq_s[i-1][l];
				end
			end
		end

		// Shift in one dividend bit and try the subtraction
		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				trial[l] = {rem_prev[l], dq_prev[l][N-1]};
				if (trial[l] >= {1'b0, dvsr_prev}) begin
					rem_nx[l] = N'(trial[l] - {1'b0, dvsr_prev});
					dq_nx[l]  = {dq_prev[l][N-2:0], 1'b1};
				end else begin
					rem_nx[l] = trial[l][N-1:0];
					dq_nx[l]  = {dq_prev[l][N-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i] <= 1'b0;
			end else if (en) begin
				valid_s[i] <= v_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dvsr_s[i] <= dvsr_prev;
				side_s[i] <= side_prev;
				for (int l = 0; l < LANES; l++) begin
					rem_s[i][l] <= rem_nx[l];
					dq_s[i][l]  <= dq_nx[l];
				end
			end
		end
	end

	// Drive the last stage out
	always_comb begin
		out_valid = valid_s[N-1];
		side_out  = side_s[N-1];
		for (int l = 0; l < LANES; l++) begin
			quo[l*N +: N] = dq_s[N-1][l];
		end
	end

endmodule

`default_nettype wire

>>> hdl/ttg_front.sv
// ----------------------------------------------------------------------------
// Triangle tangent generator - front end
// Unpacks the triangle, forms edges and UV deltas, the determinant, the
// tangent numerators and the squared normal length, and prepares the
// magnitudes for division.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttg_front #(
	parameter int COMPONENT_WIDTH = 16
) (
	input  logic                                               clk,
	input  logic                                               arst_n,
	input  logic                                               en,
	input  logic                                               in_valid,
	input  logic [ttg_pkg::POS_W-1:0]                          pos_a,
	input  logic [ttg_pkg::POS_W-1:0]                          pos_b,
	input  logic [ttg_pkg::POS_W-1:0]                          pos_c,
	input  logic [ttg_pkg::UV_W-1:0]                           uv_a,
	input  logic [ttg_pkg::UV_W-1:0]                           uv_b,
	input  logic [ttg_pkg::UV_W-1:0]                           uv_c,
	input  logic [ttg_pkg::NRM_W-1:0]                          normal_a,
	output logic                                               out_valid,
	output logic [ttg_pkg::LANES*(COMPONENT_WIDTH+1)-1:0]      d_flat,
	output logic [ttg_pkg::LANES*COMPONENT_WIDTH-1:0]          n_flat,
	output logic [ttg_pkg::LANES*ttg_pkg::MAG_W-1:0]           num_mag,
	output logic [ttg_pkg::LANES-1:0]                          q_neg,
	output logic [ttg_pkg::MAG_W-1:0]                          det_mag,
	output logic                                               det_zero,
	output logic [ttg_pkg::MAG_W-1:0]                          len2
);
	import ttg_pkg::*;

	localparam int CW = COMPONENT_WIDTH;
	localparam int DW = CW + 1;
	localparam int PW = 2 * DW;
	localparam int NW = 2 * CW;

	// Component k of a packed word; components past the carrier read as zero
	function automatic logic signed [CW-1:0] comp(input logic [EXT_W-1:0] w, input int k);
		logic signed [CW-1:0] c;
		c = '0;
		if (k * CW < WORD_W) begin
			c = w[k*CW +: CW];
		end
		return c;
	endfunction

	logic signed [DW-1:0] d_c [LANES];
	logic signed [DW-1:0] e_c [LANES];
	logic signed [CW-1:0] n_c [LANES];
	logic signed [DW-1:0] fx_c, fy_c, gx_c, gy_c;

	logic                 v_s1, v_s2, v_s3, v_s4;
	logic signed [DW-1:0] d_s1 [LANES];
	logic signed [DW-1:0] e_s1 [LANES];
	logic signed [CW-1:0] n_s1 [LANES];
	logic signed [DW-1:0] fx_s1, fy_s1, gx_s1, gy_s1;

	logic signed [PW-1:0] pd1_s2, pd2_s2;
	logic signed [PW-1:0] pa_s2 [LANES];
	logic signed [PW-1:0] pb_s2 [LANES];
	logic signed [NW-1:0] nn_s2 [LANES];
	logic signed [DW-1:0] d_s2  [LANES];
	logic signed [CW-1:0] n_s2  [LANES];

	logic signed [WORD_W-1:0] det_s3, l01_s3, nn2_s3;
	logic signed [WORD_W-1:0] num_s3 [LANES];
	logic signed [DW-1:0]     d_s3   [LANES];
	logic signed [CW-1:0]     n_s3   [LANES];

	logic signed [WORD_W-1:0] nums_c [LANES];
	logic signed [WORD_W-1:0] len2_c;
	logic [MAG_W-1:0]         nmag_s4 [LANES];
	logic [LANES-1:0]         qneg_s4;
	logic [MAG_W-1:0]         dmag_s4, len2_s4;
	logic                     dz_s4;
	logic signed [DW-1:0]     d_s4 [LANES];
	logic signed [CW-1:0]     n_s4 [LANES];

	// Unpack and take differences
	always_comb begin
		for (int j = 0; j < LANES; j++) begin
			d_c[j] = DW'(comp(EXT_W'(pos_b), j)) - DW'(comp(EXT_W'(pos_a), j));
			e_c[j] = DW'(comp(EXT_W'(pos_c), j)) - DW'(comp(EXT_W'(pos_a), j));
			n_c[j] = comp(EXT_W'(normal_a), j);
		end
		fx_c = DW'(comp(EXT_W'(uv_b), 0)) - DW'(comp(EXT_W'(uv_a), 0));
		fy_c = DW'(comp(EXT_W'(uv_b), 1)) - DW'(comp(EXT_W'(uv_a), 1));
		gx_c = DW'(comp(EXT_W'(uv_c), 0)) - DW'(comp(EXT_W'(uv_a), 0));
		gy_c = DW'(comp(EXT_W'(uv_c), 1)) - DW'(comp(EXT_W'(uv_a), 1));
	end

	// Scale numerators and length for the dividers
	always_comb begin
		for (int j = 0; j < LANES; j++) begin
			nums_c[j] = sat64(EXT_W'(num_s3[j]) <<< UV_FRAC);
		end
		len2_c = sat64(EXT_W'(l01_s3) + EXT_W'(nn2_s3));
	end

	// Advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Advance the payload
	always_ff @(posedge clk) begin
		if (en) begin
			fx_s1  <= fx_c;
			fy_s1  <= fy_c;
			gx_s1  <= gx_c;
			gy_s1  <= gy_c;
			pd1_s2 <= fx_s1 * gy_s1;
			pd2_s2 <= gx_s1 * fy_s1;
			det_s3 <= sat64(EXT_W'(sat64(EXT_W'(pd1_s2))) - EXT_W'(sat64(EXT_W'(pd2_s2))));
			l01_s3 <= sat64(EXT_W'(sat64(EXT_W'(nn_s2[0]))) + EXT_W'(sat64(EXT_W'(nn_s2[1]))));
			nn2_s3 <= sat64(EXT_W'(nn_s2[2]));
			dmag_s4 <= mag63(det_s3);
			dz_s4   <= (det_s3 == '0);
			len2_s4 <= len2_c[MAG_W-1:0];
			for (int j = 0; j < LANES; j++) begin
				d_s1[j]   <= d_c[j];
				e_s1[j]   <= e_c[j];
				n_s1[j]   <= n_c[j];
				pa_s2[j]  <= gy_s1 * d_s1[j];
				pb_s2[j]  <= gx_s1 * e_s1[j];
				nn_s2[j]  <= n_s1[j] * n_s1[j];
				d_s2[j]   <= d_s1[j];
				n_s2[j]   <= n_s1[j];
				num_s3[j] <= sat64(EXT_W'(sat64(EXT_W'(pa_s2[j])))
					- EXT_W'(sat64(EXT_W'(pb_s2[j]))));
				d_s3[j]   <= d_s2[j];
				n_s3[j]   <= n_s2[j];
				nmag_s4[j] <= mag63(nums_c[j]);
				qneg_s4[j] <= nums_c[j][WORD_W-1] ^ det_s3[WORD_W-1];
				d_s4[j]   <= d_s3[j];
				n_s4[j]   <= n_s3[j];
			end
		end
	end

	// Pack the stage outputs
	always_comb begin
		out_valid = v_s4;
		q_neg     = qneg_s4;
		det_mag   = dmag_s4;
		det_zero  = dz_s4;
		len2      = len2_s4;
		for (int j = 0; j < LANES; j++) begin
			d_flat[j*DW +: DW]       = d_s4[j];
			n_flat[j*CW +: CW]       = n_s4[j];
			num_mag[j*MAG_W +: MAG_W] = nmag_s4[j];
		end
	end

endmodule

`default_nettype wire

>>> hdl/ttg_mid.sv
// ----------------------------------------------------------------------------
// Triangle tangent generator - projection middle
// Signs the tangent quotient, forms N.T and N*(N.T) with split multiplies,
// and prepares the projection terms for the second divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttg_mid #(
	parameter int COMPONENT_WIDTH = 16
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          en,
	input  logic                                          in_valid,
	input  logic [ttg_pkg::LANES*ttg_pkg::MAG_W-1:0]      quo,
	input  logic [ttg_pkg::LANES*(COMPONENT_WIDTH+1)-1:0] d_flat,
	input  logic [ttg_pkg::LANES*COMPONENT_WIDTH-1:0]     n_flat,
	input  logic [ttg_pkg::LANES-1:0]                     q_neg,
	input  logic                                          det_zero,
	input  logic [ttg_pkg::MAG_W-1:0]                     len2_in,
	output logic                                          out_valid,
	output logic [ttg_pkg::LANES*ttg_pkg::WORD_W-1:0]     t_flat,
	output logic [ttg_pkg::LANES*ttg_pkg::MAG_W-1:0]      pr_mag,
	output logic [ttg_pkg::LANES-1:0]                     p_neg,
	output logic [ttg_pkg::MAG_W-1:0]                     len2,
	output logic                                          len2_zero,
	output logic                                          degenerate
);
	import ttg_pkg::*;

	localparam int CW = COMPONENT_WIDTH;
	localparam int DW = CW + 1;
	localparam int LW = CW + HALF_W + 1;
	localparam int HW = CW + HALF_W;

	logic signed [DW-1:0] d_in   [LANES];
	logic signed [CW-1:0] n_in   [LANES];
	logic [MAG_W-1:0]     quo_in [LANES];

	logic v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12;

	logic signed [WORD_W-1:0] t_s5 [LANES];
	logic signed [WORD_W-1:0] t_s6 [LANES];
	logic signed [WORD_W-1:0] t_s7 [LANES];
	logic signed [WORD_W-1:0] t_s8 [LANES];
	logic signed [WORD_W-1:0] t_s9 [LANES];
	logic signed [WORD_W-1:0] t_s10 [LANES];
	logic signed [WORD_W-1:0] t_s11 [LANES];
	logic signed [WORD_W-1:0] t_s12 [LANES];
	logic signed [CW-1:0]     n_s5 [LANES];
	logic signed [CW-1:0]     n_s6 [LANES];
	logic signed [CW-1:0]     n_s7 [LANES];
	logic signed [CW-1:0]     n_s8 [LANES];
	logic signed [CW-1:0]     n_s9 [LANES];
	logic [MAG_W-1:0] len2_s5, len2_s6, len2_s7, len2_s8, len2_s9, len2_s10, len2_s11;
	logic [MAG_W-1:0] len2_s12;
	logic deg_s5, deg_s6, deg_s7, deg_s8, deg_s9, deg_s10, deg_s11, deg_s12;

	logic signed [LW-1:0]     lo_s6  [LANES];
	logic signed [HW-1:0]     hi_s6  [LANES];
	logic signed [WORD_W-1:0] m_s7   [LANES];
	logic signed [WORD_W-1:0] s01_s8, m2_s8, dnt_s9;
	logic signed [LW-1:0]     lo_s10 [LANES];
	logic signed [HW-1:0]     hi_s10 [LANES];
	logic signed [WORD_W-1:0] pr_s11 [LANES];
	logic [MAG_W-1:0]         prm_s12 [LANES];
	logic [LANES-1:0]         pneg_s12;
	logic                     lz_s12;

	// Unpack the sideband
	always_comb begin
		for (int j = 0; j < LANES; j++) begin
			d_in[j]   = $signed(d_flat[j*DW +: DW]);
			n_in[j]   = $signed(n_flat[j*CW +: CW]);
			quo_in[j] = quo[j*MAG_W +: MAG_W];
		end
	end

	// Advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
		end else if (en) begin
			v_s5  <= in_valid;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
		end
	end

	// Advance the payload
	always_ff @(posedge clk) begin
		if (en) begin
			len2_s5  <= len2_in;
			len2_s6  <= len2_s5;
			len2_s7  <= len2_s6;
			len2_s8  <= len2_s7;
			len2_s9  <= len2_s8;
			len2_s10 <= len2_s9;
			len2_s11 <= len2_s10;
			len2_s12 <= len2_s11;
			deg_s5   <= det_zero;
			deg_s6   <= deg_s5;
			deg_s7   <= deg_s6;
			deg_s8   <= deg_s7;
			deg_s9   <= deg_s8;
			deg_s10  <= deg_s9;
			deg_s11  <= deg_s10;
			deg_s12  <= deg_s11;
			// Dot product N.T
			s01_s8 <= sat64(EXT_W'(m_s7[0]) + EXT_W'(m_s7[1]));
			m2_s8  <= m_s7[2];
			dnt_s9 <= sat64(EXT_W'(s01_s8) + EXT_W'(m2_s8));
			lz_s12 <= (len2_s11 == '0);
			for (int j = 0; j < LANES; j++) begin
				// Tangent: edge D when the determinant vanished
				t_s5[j] <= det_zero ? WORD_W'(d_in[j]) : sgn_val(quo_in[j], q_neg[j]);
				n_s5[j] <= n_in[j];
				// N_j * T_j in two halves
				lo_s6[j] <= n_s5[j] * $signed({1'b0, t_s5[j][HALF_W-1:0]});
				hi_s6[j] <= n_s5[j] * $signed(t_s5[j][WORD_W-1:HALF_W]);
				t_s6[j]  <= t_s5[j];
				n_s6[j]  <= n_s5[j];
				m_s7[j]  <= sat64((EXT_W'(hi_s6[j]) <<< HALF_W) + EXT_W'(lo_s6[j]));
				t_s7[j]  <= t_s6[j];
				n_s7[j]  <= n_s6[j];
				t_s8[j]  <= t_s7[j];
				n_s8[j]  <= n_s7[j];
				t_s9[j]  <= t_s8[j];
				n_s9[j]  <= n_s8[j];
				// N_j * (N.T) in two halves
				lo_s10[j] <= n_s9[j] * $signed({1'b0, dnt_s9[HALF_W-1:0]});
				hi_s10[j] <= n_s9[j] * $signed(dnt_s9[WORD_W-1:HALF_W]);
				t_s10[j]  <= t_s9[j];
				pr_s11[j] <= sat64((EXT_W'(hi_s10[j]) <<< HALF_W) + EXT_W'(lo_s10[j]));
				t_s11[j]  <= t_s10[j];
				prm_s12[j]  <= mag63(pr_s11[j]);
				pneg_s12[j] <= pr_s11[j][WORD_W-1];
				t_s12[j]    <= t_s11[j];
			end
		end
	end

	// Pack the stage outputs
	always_comb begin
		out_valid  = v_s12;
		p_neg      = pneg_s12;
		len2       = len2_s12;
		len2_zero  = lz_s12;
		degenerate = deg_s12;
		for (int j = 0; j < LANES; j++) begin
			t_flat[j*WORD_W +: WORD_W] = t_s12[j];
			pr_mag[j*MAG_W +: MAG_W]   = prm_s12[j];
		end
	end

endmodule

`default_nettype wire

>>> hdl/ttg_back.sv
// ----------------------------------------------------------------------------
// Triangle tangent generator - back end
// Subtracts the projection from the tangent, clamps each component to
// the component range and packs the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttg_back #(
	parameter int COMPONENT_WIDTH = 16
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      en,
	input  logic                                      in_valid,
	input  logic [ttg_pkg::LANES*ttg_pkg::MAG_W-1:0]  quo,
	input  logic [ttg_pkg::LANES*ttg_pkg::WORD_W-1:0] t_flat,
	input  logic [ttg_pkg::LANES-1:0]                 p_neg,
	input  logic                                      len2_zero,
	input  logic                                      deg_in,
	output logic                                      out_valid,
	output logic [ttg_pkg::TAN_W-1:0]                 tangent,
	output logic                                      degenerate
);
	import ttg_pkg::*;

	localparam int CW = COMPONENT_WIDTH;
	localparam logic signed [WORD_W-1:0] CMAX = (64'sd1 <<< (CW - 1)) - 64'sd1;
	localparam logic signed [WORD_W-1:0] CMIN = -CMAX - 64'sd1;

	logic signed [WORD_W-1:0] t_in [LANES];
	logic signed [WORD_W-1:0] r_c  [LANES];
	logic                     v_s13, v_s14;
	logic signed [WORD_W-1:0] r_s13 [LANES];
	logic                     deg_s13, deg_s14;
	logic signed [WORD_W-1:0] clp_c [LANES];
	logic [EXT_W-1:0]         pack_c;
	logic [TAN_W-1:0]         tan_s14;

	// Remove the normal component unless the normal is zero
	always_comb begin
		for (int j = 0; j < LANES; j++) begin
			t_in[j] = $signed(t_flat[j*WORD_W +: WORD_W]);
			if (len2_zero) begin
				r_c[j] = t_in[j];
			end else begin
				r_c[j] = sat64(EXT_W'(t_in[j])
					- EXT_W'(sgn_val(quo[j*MAG_W +: MAG_W], p_neg[j])));
			end
		end
	end

	// Clamp and pack the components
	always_comb begin
		pack_c = '0;
		for (int j = 0; j < LANES; j++) begin
			if (r_s13[j] > CMAX) begin
				clp_c[j] = CMAX;
			end else if (r_s13[j] < CMIN) begin
				clp_c[j] = CMIN;
			end else begin
				clp_c[j] = r_s13[j];
			end
			if (j * CW < WORD_W) begin
				pack_c = pack_c | (EXT_W'(clp_c[j][CW-1:0]) << (j * CW));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s13 <= 1'b0;
			v_s14 <= 1'b0;
		end else if (en) begin
			v_s13 <= in_valid;
			v_s14 <= v_s13;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			deg_s13 <= deg_in;
			deg_s14 <= deg_s13;
			tan_s14 <= pack_c[TAN_W-1:0];
			for (int j = 0; j < LANES; j++) begin
				r_s13[j] <= r_c[j];
			end
		end
	end

	assign out_valid  = v_s14;
	assign tangent    = tan_s14;
	assign degenerate = deg_s14;

endmodule

`default_nettype wire

>>> hdl/triangle_tangent_generator_unit.sv
// ----------------------------------------------------------------------------
// Triangle tangent generator - top level
// Takes one triangle per item and returns its tangent, made orthogonal to
// the first vertex normal and clamped per component, plus a degenerate flag.
//
// Input channel tri_valid/tri_stall carries pos_a..c, uv_a..c, normal_a; an
// item is taken on an edge with tri_valid high and tri_stall low.
// Output channel tan_valid/tan_stall carries tangent and degenerate.
// One item per cycle is accepted while tri_stall is low. From the accepting
// edge to tan_valid an item passes four front stages, 63 stages of the
// tangent divider (one quotient bit each), eight projection stages, 63
// stages of the projection divider, two back stages and the output register.
// When the receiver stalls, the finished item holds on the output and one
// more result lands in a skid register; only then does tri_stall rise and
// the whole pipeline freeze, losing nothing.
// Reset clears all valid bits; no item is in flight afterwards.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module triangle_tangent_generator_unit #(
	parameter int COMPONENT_WIDTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       tri_valid,
	output logic                       tri_stall,
	input  logic [ttg_pkg::POS_W-1:0]  pos_a,
	input  logic [ttg_pkg::POS_W-1:0]  pos_b,
	input  logic [ttg_pkg::POS_W-1:0]  pos_c,
	input  logic [ttg_pkg::UV_W-1:0]   uv_a,
	input  logic [ttg_pkg::UV_W-1:0]   uv_b,
	input  logic [ttg_pkg::UV_W-1:0]   uv_c,
	input  logic [ttg_pkg::NRM_W-1:0]  normal_a,
	output logic                       tan_valid,
	input  logic                       tan_stall,
	output logic [ttg_pkg::TAN_W-1:0]  tangent,
	output logic                       degenerate
);
	import ttg_pkg::*;

	localparam int CW     = COMPONENT_WIDTH;
	localparam int DW     = CW + 1;
	localparam int A_D    = 0;
	localparam int A_N    = A_D + LANES * DW;
	localparam int A_Q    = A_N + LANES * CW;
	localparam int A_Z    = A_Q + LANES;
	localparam int A_L    = A_Z + 1;
	localparam int SIDE_A = A_L + MAG_W;
	localparam int B_T    = 0;
	localparam int B_P    = B_T + LANES * WORD_W;
	localparam int B_Z    = B_P + LANES;
	localparam int B_G    = B_Z + 1;
	localparam int SIDE_B = B_G + 1;

	logic en;

	logic                      f_valid;
	logic [LANES*DW-1:0]       f_d;
	logic [LANES*CW-1:0]       f_n;
	logic [LANES*MAG_W-1:0]    f_num;
	logic [LANES-1:0]          f_qneg;
	logic [MAG_W-1:0]          f_det;
	logic                      f_dz;
	logic [MAG_W-1:0]          f_len2;
	logic [SIDE_A-1:0]         side_a_in, side_a_out;

	logic                      da_valid;
	logic [LANES*MAG_W-1:0]    da_quo;

	logic                      m_valid;
	logic [LANES*WORD_W-1:0]   m_t;
	logic [LANES*MAG_W-1:0]    m_pr;
	logic [LANES-1:0]          m_pneg;
	logic [MAG_W-1:0]          m_len2;
	logic                      m_lz;
	logic                      m_deg;
	logic [SIDE_B-1:0]         side_b_in, side_b_out;

	logic                      db_valid;
	logic [LANES*MAG_W-1:0]    db_quo;

	logic                      r_valid;
	logic [TAN_W-1:0]          r_tangent;
	logic                      r_deg;

	logic                      tan_valid_q, skid_valid_q;
	logic [TAN_W-1:0]          tangent_q, skid_tangent_q;
	logic                      degenerate_q, skid_degenerate_q;

	// Freeze the pipeline only while the skid register is occupied
	assign en        = !skid_valid_q;
	assign tri_stall = skid_valid_q;

	ttg_front #(.COMPONENT_WIDTH(COMPONENT_WIDTH)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (tri_valid),
		.pos_a    (pos_a),
		.pos_b    (pos_b),
		.pos_c    (pos_c),
		.uv_a     (uv_a),
		.uv_b     (uv_b),
		.uv_c     (uv_c),
		.normal_a (normal_a),
		.out_valid(f_valid),
		.d_flat   (f_d),
		.n_flat   (f_n),
		.num_mag  (f_num),
		.q_neg    (f_qneg),
		.det_mag  (f_det),
		.det_zero (f_dz),
		.len2     (f_len2)
	);

	assign side_a_in = {f_len2, f_dz, f_qneg, f_n, f_d};

	ttg_div #(.N(MAG_W), .SIDE_W(SIDE_A)) u_div_tan (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (f_valid),
		.dvd      (f_num),
		.dvsr     (f_det),
		.side_in  (side_a_in),
		.out_valid(da_valid),
		.quo      (da_quo),
		.side_out (side_a_out)
	);

	ttg_mid #(.COMPONENT_WIDTH(COMPONENT_WIDTH)) u_mid (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (da_valid),
		.quo       (da_quo),
		.d_flat    (side_a_out[A_D +: LANES*DW]),
		.n_flat    (side_a_out[A_N +: LANES*CW]),
		.q_neg     (side_a_out[A_Q +: LANES]),
		.det_zero  (side_a_out[A_Z]),
		.len2_in   (side_a_out[A_L +: MAG_W]),
		.out_valid (m_valid),
		.t_flat    (m_t),
		.pr_mag    (m_pr),
		.p_neg     (m_pneg),
		.len2      (m_len2),
		.len2_zero (m_lz),
		.degenerate(m_deg)
	);

	assign side_b_in = {m_deg, m_lz, m_pneg, m_t};

	ttg_div #(.N(MAG_W), .SIDE_W(SIDE_B)) u_div_prj (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (m_valid),
		.dvd      (m_pr),
		.dvsr     (m_len2),
		.side_in  (side_b_in),
		.out_valid(db_valid),
		.quo      (db_quo),
		.side_out (side_b_out)
	);

	ttg_back #(.COMPONENT_WIDTH(COMPONENT_WIDTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (db_valid),
		.quo       (db_quo),
		.t_flat    (side_b_out[B_T +: LANES*WORD_W]),
		.p_neg     (side_b_out[B_P +: LANES]),
		.len2_zero (side_b_out[B_Z]),
		.deg_in    (side_b_out[B_G]),
		.out_valid (r_valid),
		.tangent   (r_tangent),
		.degenerate(r_deg)
	);

	// Output register with one skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tan_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (tan_valid_q && tan_stall) begin
			if (r_valid && !skid_valid_q) begin
				skid_valid_q <= 1'b1;
			end
		end else if (skid_valid_q) begin
			tan_valid_q  <= 1'b1;
			skid_valid_q <= 1'b0;
		end else begin
			tan_valid_q <= r_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tan_valid_q && tan_stall) begin
			if (!skid_valid_q) begin
				skid_tangent_q    <= r_tangent;
				skid_degenerate_q <= r_deg;
			end
		end else if (skid_valid_q) begin
			tangent_q    <= skid_tangent_q;
			degenerate_q <= skid_degenerate_q;
		end else begin
			tangent_q    <= r_tangent;
			degenerate_q <= r_deg;
		end
	end

	assign tan_valid  = tan_valid_q;
	assign tangent    = tangent_q;
	assign degenerate = degenerate_q;

endmodule

`default_nettype wire
